[hw/rtl/lro_pkg.sv]
// ----------------------------------------------------------------------------
// lro_pkg: shared constants and types for the line-robust log-odds scorer
// Fixed field widths, math constants and pipeline depths used by all modules.
// ----------------------------------------------------------------------------
package lro_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxDetDefault   = 4;
  localparam int unsigned FracBitsDefault = 12;

  // Field and datapath widths
  localparam int unsigned InW      = 31;   // one 2F statistic
  localparam int unsigned CfgW     = 32;   // widest register
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumDet   = 4;    // detector fields in one item
  localparam int unsigned InDataW  = 160;  // 5 x 31 bits, padded to bytes
  localparam int unsigned OutW     = 32;
  localparam int unsigned TermW    = 34;   // terms in Q.(F+1)
  localparam int unsigned DiffW    = 35;   // differences of terms
  localparam int unsigned Q30W     = 31;   // unsigned Q.30 values up to one
  localparam int unsigned SumW     = 33;   // sum of five Q.30 exponentials
  localparam int unsigned LuW      = 33;   // log correction
  localparam int unsigned TvalW    = 44;   // log odds in Q.(F+1+ExtraBits)
  localparam int unsigned ExtraBits = 8;

  // Math constants
  localparam logic [30:0] Q30One    = 31'h4000_0000;
  localparam logic [29:0] Ln2Q30    = 30'd744261118;
  localparam logic [38:0] Log10eQ40 = 39'd477511832732;
  localparam logic [31:0] ExcludedMark = 32'h8000_0000;

  // Series lengths and unit latencies
  localparam int unsigned ExpSteps = 16;
  localparam int unsigned LnTerms  = 12;
  localparam int unsigned DivBits  = 30;
  localparam int unsigned ExpLat   = 2 + 3 * ExpSteps + 1;
  localparam int unsigned LnLat    = 1 + DivBits + 1 + 2 * LnTerms + 1;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegNumDet  = 3'd0,
    RegLogCorr = 3'd1,
    RegCommon  = 3'd2,
    RegDet0    = 3'd3,
    RegDet1    = 3'd4,
    RegDet2    = 3'd5,
    RegDet3    = 3'd6
  } cfg_reg_e;

endpackage

[hw/rtl/lro_exp.sv]
// ----------------------------------------------------------------------------
// lro_exp: pipelined exp(-x) lane
// Range reduction by ln2, then one Taylor term per three stages, result Q.30.
// ----------------------------------------------------------------------------
module lro_exp
  import lro_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    use_i,
  input  logic signed [DiffW-1:0] x_i,
  output logic [Q30W-1:0]         exp_o
);

  localparam logic [DiffW-1:0] XLimit   = DiffW'(40) << (FracBits + 1);
  localparam logic [6:0]       RecipLn2 = 7'((64'd1 << 36) / 64'(Ln2Q30));

  // Range reduction, stage A: estimate k = x / ln2
  logic [35:0] x30_a;
  logic        zero_a;
  logic [42:0] kprod_a;
  logic [35:0] x30_qa;
  logic [5:0]  k_qa;
  logic        zero_qa;

  always_comb begin
    zero_a  = !use_i || (!x_i[DiffW-1] && (x_i >= $signed(XLimit)));
    x30_a   = (x_i[DiffW-1] || zero_a) ? '0 : (36'(x_i) << (29 - FracBits));
    kprod_a = 43'(x30_a) * 43'(RecipLn2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x30_qa  <= x30_a;
      k_qa    <= kprod_a[41:36];
      zero_qa <= zero_a;
    end
  end

  // Stage B: one correction step gives exact k and remainder r
  logic [35:0] rem_b;
  logic        fix_b;

  logic [Q30W-1:0] t_s   [ExpSteps+1];
  logic [Q30W-1:0] acc_s [ExpSteps+1];
  logic [29:0]     r_s   [ExpSteps+1];
  logic [5:0]      k_s   [ExpSteps+1];
  logic            z_s   [ExpSteps+1];

  always_comb begin
    rem_b = x30_qa - 36'(k_qa) * 36'(Ln2Q30);
    fix_b = rem_b >= 36'(Ln2Q30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_s[0]   <= fix_b ? 30'(rem_b - 36'(Ln2Q30)) : rem_b[29:0];
      k_s[0]   <= fix_b ? k_qa + 6'd1 : k_qa;
      z_s[0]   <= zero_qa;
      t_s[0]   <= Q30One;
      acc_s[0] <= Q30One;
    end
  end

  // Taylor terms: t = ((t * r) >> 30) / n, alternating sum
  for (genvar s = 0; s < ExpSteps; s++) begin : g_step
    localparam int unsigned N = s + 1;

    logic [60:0]     tr;
    logic [Q30W-1:0] p1_q, acc1_q, p2_q, qe2_q, acc2_q, qe;
    logic [29:0]     r1_q, r2_q;
    logic [5:0]      k1_q, k2_q;
    logic            z1_q, z2_q;
    logic [35:0]     rem;
    logic [Q30W-1:0] q;

    assign tr = 61'(t_s[s]) * 61'(r_s[s]);

    if (N == 1) begin : g_unit
      assign qe = p1_q;
    end else begin : g_recip
      localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(N));
      logic [63:0] qp;
      assign qp = 64'(p1_q) * 64'(Recip);
      assign qe = qp[62:32];
    end

    // Divide by constant: estimate is low by at most one
    always_comb begin
      rem = 36'(p2_q) - 36'(qe2_q) * 36'(N);
      q   = (rem >= 36'(N)) ? qe2_q + 1'b1 : qe2_q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p1_q     <= tr[60:30];
        acc1_q   <= acc_s[s];
        r1_q     <= r_s[s];
        k1_q     <= k_s[s];
        z1_q     <= z_s[s];
        p2_q     <= p1_q;
        qe2_q    <= qe;
        acc2_q   <= acc1_q;
        r2_q     <= r1_q;
        k2_q     <= k1_q;
        z2_q     <= z1_q;
        t_s[s+1]   <= q;
        acc_s[s+1] <= (N % 2 == 1) ? acc2_q - q : acc2_q + q;
        r_s[s+1]   <= r2_q;
        k_s[s+1]   <= k2_q;
        z_s[s+1]   <= z2_q;
      end
    end
  end

  // Scale by 2^-k
  logic [Q30W-1:0] exp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q <= (z_s[ExpSteps] || k_s[ExpSteps] >= 6'd31) ? '0
             : acc_s[ExpSteps] >> k_s[ExpSteps];
    end
  end

  assign exp_o = exp_q;

endmodule

[hw/rtl/lro_ln.sv]
// ----------------------------------------------------------------------------
// lro_ln: pipelined natural log of the exponential sum
// Normalizes to [1,2), bit-per-stage divider, atanh series, rounds the result.
// ----------------------------------------------------------------------------
module lro_ln
  import lro_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SumW-1:0] s_i,
  output logic [LuW-1:0]  lu_o
);

  localparam int unsigned Sh = 30 - (FracBits + 1 + ExtraBits);

  // Normalize: s in [2^30, 2^31), e counts the halvings
  logic [1:0]  e_n;
  logic [30:0] sn;

  always_comb begin
    priority if (s_i[32]) e_n = 2'd2;
    else if (s_i[31])     e_n = 2'd1;
    else                  e_n = 2'd0;
    sn = 31'(s_i >> e_n);
  end

  logic [32:0] rem_s [DivBits+1];
  logic [31:0] den_s [DivBits+1];
  logic [29:0] quo_s [DivBits+1];
  logic [1:0]  e_s   [DivBits+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_s[0] <= 33'(sn - Q30One);
      den_s[0] <= 32'(sn) + 32'(Q30One);
      quo_s[0] <= '0;
      e_s[0]   <= e_n;
    end
  end

  // Restoring division, one quotient bit per stage: y = (s-1)/(s+1)
  for (genvar i = 0; i < DivBits; i++) begin : g_div
    logic [32:0] r2;
    logic        bit_q;

    always_comb begin
      r2    = {rem_s[i][31:0], 1'b0};
      bit_q = r2 >= 33'(den_s[i]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[i+1] <= bit_q ? r2 - 33'(den_s[i]) : r2;
        den_s[i+1] <= den_s[i];
        quo_s[i+1] <= {quo_s[i][28:0], bit_q};
        e_s[i+1]   <= e_s[i];
      end
    end
  end

  // y^2
  logic [59:0] yy;
  assign yy = 60'(quo_s[DivBits]) * 60'(quo_s[DivBits]);

  logic [29:0] t_s   [LnTerms+1];
  logic [29:0] y2_s  [LnTerms+1];
  logic [31:0] sum_s [LnTerms+1];
  logic [1:0]  ee_s  [LnTerms+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_s[0]   <= quo_s[DivBits];
      y2_s[0]  <= yy[59:30];
      sum_s[0] <= '0;
      ee_s[0]  <= e_s[DivBits];
    end
  end

  // Series: sum += t / (2n+1), t = t * y^2
  for (genvar n = 0; n < LnTerms; n++) begin : g_term
    localparam int unsigned D = 2 * n + 1;

    logic [59:0] ty;
    logic [29:0] qe, t1_q, qe1_q, tn1_q, y21_q;
    logic [31:0] sum1_q;
    logic [1:0]  e1_q;
    logic [35:0] rem;
    logic [29:0] q;

    assign ty = 60'(t_s[n]) * 60'(y2_s[n]);

    if (D == 1) begin : g_unit
      assign qe = t_s[n];
    end else begin : g_recip
      localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(D));
      logic [61:0] qp;
      assign qp = 62'(t_s[n]) * 62'(Recip);
      assign qe = qp[61:32];
    end

    always_comb begin
      rem = 36'(t1_q) - 36'(qe1_q) * 36'(D);
      q   = (rem >= 36'(D)) ? qe1_q + 1'b1 : qe1_q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t1_q   <= t_s[n];
        qe1_q  <= qe;
        tn1_q  <= ty[59:30];
        y21_q  <= y2_s[n];
        sum1_q <= sum_s[n];
        e1_q   <= ee_s[n];
        t_s[n+1]   <= tn1_q;
        y2_s[n+1]  <= y21_q;
        sum_s[n+1] <= sum1_q + 32'(q);
        ee_s[n+1]  <= e1_q;
      end
    end
  end

  // ln = 2*sum + e*ln2, rounded half up to the output precision
  logic [LuW-1:0] l30;
  logic [LuW-1:0] lu_q;

  assign l30 = {sum_s[LnTerms], 1'b0} + LuW'(ee_s[LnTerms]) * LuW'(Ln2Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lu_q <= (l30 + (LuW'(1) << (Sh - 1))) >> Sh;
    end
  end

  assign lu_o = lu_q;

endmodule

[hw/rtl/line_robust_log_odds.sv]
// ----------------------------------------------------------------------------
// line_robust_log_odds: line-robust log10 Bayes factor, one item per cycle
// Input: s_axis_* carries 2F and the per-detector 2F values. Output: m_axis_*
// carries log10_odds in signed Q.F, saturated to 32 bits.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i, by the
// user only while the block is idle (the block does not enforce this); an
// index beyond the register list is ignored. A new item is taken every cycle
// while the output does not stall. The exp lanes (Taylor series, three stages
// per term) and the log unit (bit-per-stage divider and series) set most of
// the pipeline depth.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and s_axis_tready_o drops, and it rises
// again in the cycle the waiting result is taken. Reset empties the pipeline
// and loads the register reset values.
// ----------------------------------------------------------------------------
module line_robust_log_odds
  import lro_pkg::*;
#(
  parameter int unsigned MAX_DETECTORS = MaxDetDefault,
  parameter int unsigned FRAC_BITS     = FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // Input stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // two_f, two_f_det0, two_f_det1, two_f_det2, two_f_det3 (31 bits each)
  input  logic [InDataW-1:0] s_axis_tdata_i,
  // Output stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // log10_odds (32 bits)
  output logic [OutW-1:0]    m_axis_tdata_o
);

  localparam int unsigned Depth  = 8 + ExpLat + LnLat;
  localparam int unsigned LnbDly = ExpLat + LnLat + 1;
  localparam int unsigned SumIdx = 4 + ExpLat;

  // Configuration registers
  logic [2:0]      n_det_q;
  logic            corr_q;
  logic [CfgW-1:0] common_q;
  logic [CfgW-1:0] det_q [NumDet];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_det_q  <= 3'd2;
      corr_q   <= 1'b1;
      common_q <= 32'hFFFF_F4E9;
      for (int i = 0; i < NumDet; i++) begin
        det_q[i] <= 32'hFFFF_E9D2;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNumDet:  n_det_q  <= cfg_wdata_i[2:0];
        RegLogCorr: corr_q   <= cfg_wdata_i[0];
        RegCommon:  common_q <= cfg_wdata_i;
        RegDet0:    det_q[0] <= cfg_wdata_i;
        RegDet1:    det_q[1] <= cfg_wdata_i;
        RegDet2:    det_q[2] <= cfg_wdata_i;
        RegDet3:    det_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamped detector count and per-detector use flags
  logic [2:0]        n_use;
  logic [NumDet-1:0] used;

  always_comb begin
    priority if (n_det_q < 3'd2)               n_use = 3'd2;
    else if (n_det_q > 3'(MAX_DETECTORS))      n_use = 3'(MAX_DETECTORS);
    else                                       n_use = n_det_q;
    for (int i = 0; i < NumDet; i++) begin
      used[i] = (3'(i) < n_use) && (i < MAX_DETECTORS) && (det_q[i] != ExcludedMark);
    end
  end

  // Pipeline valid chain and global advance
  logic [Depth-1:0] vld_q;
  logic             en;

  assign en = !vld_q[Depth-1] || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid_i};
    end
  end

  // Stage 1: terms in Q.(F+1)
  logic signed [TermW-1:0] term_q [NumDet];
  logic signed [TermW-1:0] c2_q;
  logic [NumDet-1:0]       used_q;
  logic [InW-1:0]          two_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumDet; i++) begin
        term_q[i] <= $signed({3'b000, s_axis_tdata_i[InW*(i+1) +: InW]})
                   + $signed({det_q[i][31], det_q[i], 1'b0});
      end
      c2_q    <= $signed({common_q[31], common_q, 1'b0});
      used_q  <= used;
      two_f_q <= s_axis_tdata_i[InW-1:0];
    end
  end

  // Stage 2: first level of the maximum
  logic signed [TermW-1:0] tg [NumDet];
  logic signed [TermW-1:0] ma_q, mb_q, mc_q, c2_2q;
  logic signed [TermW-1:0] term_2q [NumDet];
  logic [NumDet-1:0]       used_2q;
  logic [InW-1:0]          two_f_2q;

  always_comb begin
    for (int i = 0; i < NumDet; i++) begin
      tg[i] = used_q[i] ? term_q[i] : c2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q     <= (tg[0] > c2_q) ? tg[0] : c2_q;
      mb_q     <= (tg[2] > tg[1]) ? tg[2] : tg[1];
      mc_q     <= tg[3];
      c2_2q    <= c2_q;
      term_2q  <= term_q;
      used_2q  <= used_q;
      two_f_2q <= two_f_q;
    end
  end

  // Stage 3: final maximum M
  logic signed [TermW-1:0] mab, m_q, c2_3q;
  logic signed [TermW-1:0] term_3q [NumDet];
  logic [NumDet-1:0]       used_3q;
  logic [InW-1:0]          two_f_3q;

  assign mab = (mb_q > ma_q) ? mb_q : ma_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q      <= (mc_q > mab) ? mc_q : mab;
      c2_3q    <= c2_2q;
      term_3q  <= term_2q;
      used_3q  <= used_2q;
      two_f_3q <= two_f_2q;
    end
  end

  // Stage 4: lnB and exponent arguments for the lanes
  logic signed [DiffW-1:0] lnb_q [LnbDly+1];
  logic signed [DiffW-1:0] xc_q;
  logic signed [DiffW-1:0] xd_q [NumDet];
  logic [NumDet-1:0]       used_4q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lnb_q[0] <= $signed({4'b0000, two_f_3q}) - $signed({m_q[TermW-1], m_q});
      xc_q     <= $signed({m_q[TermW-1], m_q}) - $signed({c2_3q[TermW-1], c2_3q});
      for (int i = 0; i < NumDet; i++) begin
        xd_q[i] <= $signed({m_q[TermW-1], m_q})
                 - $signed({term_3q[i][TermW-1], term_3q[i]});
      end
      used_4q <= used_3q;
      for (int j = 1; j <= LnbDly; j++) begin
        lnb_q[j] <= lnb_q[j-1];
      end
    end
  end

  // Exponential lanes: common term plus one per detector below MAX_DETECTORS
  logic [Q30W-1:0] ex_c;
  logic [Q30W-1:0] ex_d [NumDet];

  lro_exp #(.FracBits(FRAC_BITS)) u_exp_c (
    .clk_i (clk_i),
    .en_i  (en),
    .use_i (1'b1),
    .x_i   (xc_q),
    .exp_o (ex_c)
  );

  for (genvar i = 0; i < NumDet; i++) begin : g_lane
    if (i < MAX_DETECTORS) begin : g_on
      lro_exp #(.FracBits(FRAC_BITS)) u_exp (
        .clk_i (clk_i),
        .en_i  (en),
        .use_i (used_4q[i]),
        .x_i   (xd_q[i]),
        .exp_o (ex_d[i])
      );
    end else begin : g_off
      assign ex_d[i] = '0;
    end
  end

  // Merge: sum of lane results
  logic [SumW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= SumW'(ex_c) + SumW'(ex_d[0]) + SumW'(ex_d[1])
             + SumW'(ex_d[2]) + SumW'(ex_d[3]);
    end
  end

  // Log correction
  logic [LuW-1:0] lu;

  lro_ln #(.FracBits(FRAC_BITS)) u_ln (
    .clk_i (clk_i),
    .en_i  (en),
    .s_i   (sum_q),
    .lu_o  (lu)
  );

  // Final stage 1: corrected log odds, sign and magnitude
  logic signed [TvalW-1:0] tval;
  logic [TvalW-1:0]        mag_q;
  logic                    neg_q;

  assign tval = $signed({lnb_q[LnbDly][DiffW-1], lnb_q[LnbDly], 8'h00})
              - $signed(corr_q ? TvalW'(lu) : TvalW'(0));

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q <= tval[TvalW-1];
      mag_q <= tval[TvalW-1] ? TvalW'(-tval) : TvalW'(tval);
    end
  end

  // Final stage 2: scale by log10(e), split into two products
  logic [58:0] ph_q;
  logic [62:0] pl;
  logic [38:0] pl_q;
  logic        neg_2q;

  assign pl = 63'(mag_q[23:0]) * 63'(Log10eQ40);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q   <= 59'(mag_q[TvalW-1:24]) * 59'(Log10eQ40);
      pl_q   <= pl[62:24];
      neg_2q <= neg_q;
    end
  end

  // Final stage 3: round and saturate into the output register
  logic [59:0]     prod;
  logic [34:0]     res;
  logic [OutW-1:0] out_d, out_q;

  always_comb begin
    prod = 60'(ph_q) + 60'(pl_q);
    res  = 35'((prod + (60'd1 << 24)) >> 25);
    if (neg_2q) begin
      out_d = (res > 35'h0_8000_0000) ? 32'h8000_0000 : 32'(-res);
    end else begin
      out_d = (res > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : res[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[Depth-1];
  assign m_axis_tdata_o  = out_q;

  // Checks
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted transfer not in first stage");

  a_sum_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SumIdx] |-> sum_q >= SumW'(Q30One))
    else $error("exponential sum below one");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_use >= 3'd2 && n_use <= 3'(MAX_DETECTORS))
    else $error("detector count out of range");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for line_robust_log_odds
// Drives 2F items through the input stream in phases of register settings,
// predicts every log10 odds value with a fixed-point model of its own and
// checks each output transfer against the oldest prediction, in order.
// ----------------------------------------------------------------------------
class odds_scoreboard;
  // shadow of the configuration registers
  logic [2:0]  n_det;
  logic        corr_on;
  logic [31:0] common;
  logic [31:0] det[4];
  logic [31:0] pending[$];
  int          errors;
  int          n_in;
  int          n_out;

  function new();
    n_det   = 3'd2;
    corr_on = 1'b1;
    common  = -32'sd2839;
    foreach (det[i]) det[i] = -32'sd5678;
    errors  = 0;
    n_in    = 0;
    n_out   = 0;
  endfunction

  function void set_reg(lro_pkg::cfg_reg_e idx, logic [31:0] val);
    case (idx)
      lro_pkg::RegNumDet:  n_det = val[2:0];
      lro_pkg::RegLogCorr: corr_on = val[0];
      lro_pkg::RegCommon:  common = val;
      lro_pkg::RegDet0:    det[0] = val;
      lro_pkg::RegDet1:    det[1] = val;
      lro_pkg::RegDet2:    det[2] = val;
      lro_pkg::RegDet3:    det[3] = val;
      default: ;
    endcase
  endfunction

  // exp(-x) in Q.30, x in Q.13
  function longint unsigned exp_q30(longint x);
    longint unsigned x30, k, r, t, acc;
    if (x < 0) x = 0;
    if (x >= (longint'(40) <<< 13)) return 0;
    x30 = longint'(x) << 17;
    k   = x30 / 744261118;
    r   = x30 - k * 744261118;
    t   = 64'd1 << 30;
    acc = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      t = ((t * r) >> 30) / n;
      if (n & 1) acc -= t;
      else acc += t;
    end
    if (k >= 31) return 0;
    return acc >> k;
  endfunction

  // ln(s) in Q.30, s in Q.30 and at least one
  function longint unsigned ln_q30(longint unsigned s);
    longint unsigned e, y, y2, t, sum;
    e   = 0;
    sum = 0;
    if (s < (64'd1 << 30)) s = 64'd1 << 30;
    while (s >= (64'd2 << 30)) begin
      s >>= 1;
      e++;
    end
    y  = ((s - (64'd1 << 30)) << 30) / (s + (64'd1 << 30));
    y2 = (y * y) >> 30;
    t  = y;
    for (int n = 0; n < 12; n++) begin
      sum += t / (2 * n + 1);
      t = (t * y2) >> 30;
    end
    return 2 * sum + e * 744261118;
  endfunction

  // log10 odds of one item
  function logic [31:0] log10_odds(logic [30:0] f[5]);
    longint          term[4], c2, m, tval;
    bit              used[4];
    int              n;
    longint unsigned s, lu, mag, prod, res;
    n  = n_det < 2 ? 2 : (n_det > 4 ? 4 : n_det);
    c2 = 2 * longint'($signed(common));
    m  = c2;
    for (int i = 0; i < 4; i++) begin
      used[i] = (i < n) && (det[i] != lro_pkg::ExcludedMark);
      term[i] = longint'({33'd0, f[i+1]}) + 2 * longint'($signed(det[i]));
      if (used[i] && term[i] > m) m = term[i];
    end
    tval = (longint'({33'd0, f[0]}) - m) <<< 8;
    if (corr_on) begin
      s = exp_q30(m - c2);
      for (int i = 0; i < 4; i++)
        if (used[i]) s += exp_q30(m - term[i]);
      lu   = (ln_q30(s) + 256) >> 9;
      tval = tval - longint'(lu);
    end
    mag  = tval < 0 ? -tval : tval;
    prod = (mag >> 24) * 64'd477511832732 + (((mag & 64'hFF_FFFF) * 64'd477511832732) >> 24);
    res  = (prod + (64'd1 << 24)) >> 25;
    if (tval < 0) begin
      if (res > 64'h8000_0000) res = 64'h8000_0000;
      return 32'(-res);
    end
    return res > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : res[31:0];
  endfunction

  function void note_input(logic [30:0] f[5]);
    pending.push_back(log10_odds(f));
    n_in++;
  endfunction

  function void check_result(logic [31:0] got);
    logic [31:0] want;
    n_out++;
    if (pending.size() == 0) begin
      $error("log10_odds: unexpected result %0d", $signed(got));
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $error("log10_odds: expected %0d, actual %0d", $signed(want), $signed(got));
      errors++;
    end
  endfunction
endclass

module tb
  import lro_pkg::*;
;
  localparam int Latency = 116;
  localparam int CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [InDataW-1:0] s_axis_tdata_i = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [OutW-1:0]    m_axis_tdata_o;

  odds_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int             cycles = 0;
  int             n_phases = 0;

  always #1 clk_i = ~clk_i;

  line_robust_log_odds dut (.*);

  // unpack the fields of an input transfer
  function automatic void split_item(logic [InDataW-1:0] d, output logic [30:0] f[5]);
    for (int i = 0; i < 5; i++) f[i] = d[31*i +: 31];
  endfunction

  // watch both streams
  always @(posedge clk_i) begin
    logic [30:0] f[5];
    cycles <= cycles + 1;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      split_item(s_axis_tdata_i, f);
      sb.note_input(f);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    if (cycles > CycleLimit) begin
      $display("line_robust_log_odds test failed");
      $finish;
    end
  end

  // receiver stalls at random, except while no_idle is set
  always @(negedge clk_i)
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= 34);

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(logic [30:0] f[5]);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 34) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'd0, f[4], f[3], f[2], f[1], f[0]};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // drain all results, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic logic [30:0] rand_stat();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return 31'($urandom);
      default: return 31'($urandom_range(200000));
    endcase
  endfunction

  function automatic logic [31:0] rand_term();
    case ($urandom_range(9))
      0: return ExcludedMark;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return 32'($signed($urandom_range(120000)) - 60000);
    endcase
  endfunction

  task automatic random_items(int count);
    logic [30:0] f[5];
    for (int k = 0; k < count; k++) begin
      foreach (f[i]) f[i] = rand_stat();
      send_item(f);
    end
  endtask

  task automatic phase(logic [2:0] nd, bit lc, logic [31:0] c, logic [31:0] d0,
                       logic [31:0] d1, logic [31:0] d2, logic [31:0] d3, int count);
    drain();
    write_reg(RegNumDet, {29'd0, nd});
    write_reg(RegLogCorr, {31'd0, lc});
    write_reg(RegCommon, c);
    write_reg(RegDet0, d0);
    write_reg(RegDet1, d1);
    write_reg(RegDet2, d2);
    write_reg(RegDet3, d3);
    n_phases++;
    random_items(count);
  endtask

  initial begin
    logic [30:0] f[5];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed items at the reset settings
    n_phases = 1;
    for (int k = 0; k < 20; k++) begin
      foreach (f[i])
        case (k % 5)
          0: f[i] = '0;
          1: f[i] = '1;
          2: f[i] = (i == k % 4 + 1) ? '1 : '0;
          3: f[i] = 31'(i * 5678 * 2);
          default: f[i] = 31'($urandom_range(40000));
        endcase
      send_item(f);
    end
    random_items(80);

    // write to an index past the register list, which the design ignores
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegDet3 + 3'd1;
    cfg_wdata_i <= '1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;

    phase(3'd4, 1'b0, rand_term(), rand_term(), rand_term(), rand_term(), rand_term(), 100);
    phase(3'd4, 1'b1, -32'sd3000, -32'sd2000, -32'sd2500, -32'sd1000, -32'sd4000, 100);
    phase(3'd3, 1'b1, 32'd0, 32'd100, -32'sd100, ExcludedMark, 32'd500, 100);
    phase(3'd0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 100);
    phase(3'd7, 1'b1, 32'h7FFF_FFFF, ExcludedMark, ExcludedMark, ExcludedMark,
          ExcludedMark, 100);
    no_idle = 1'b1;
    phase(3'd4, 1'b1, 32'd0, $urandom, $urandom, $urandom, $urandom, 100);
    no_idle = 1'b0;
    phase(3'd1, 1'b0, rand_term(), rand_term(), rand_term(), rand_term(), rand_term(), 100);
    phase(3'd4, 1'b1, rand_term(), rand_term(), rand_term(), rand_term(), rand_term(), 100);

    drain();
    $display("Covered %0d register phases: %0d items sent, %0d results checked.",
             n_phases, sb.n_in, sb.n_out);
    if (sb.errors == 0) begin
      $display("line_robust_log_odds test passed");
    end else begin
      $display("line_robust_log_odds test failed");
    end
    $finish;
  end
endmodule
